// ----- hdl/assert_macros.svh -----
// assertion macros shared by the rtl files
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sfpac_pkg.sv -----
// types and constants for the sync frame parser with additive checksum
// no dependencies
package sfpac_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int STATUS_W  = 3;
  localparam int POS_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SYNC     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_VERSION  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CHECKSUM = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LENGTH   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd2;

  localparam logic [POS_W-1:0] OFS_SYNC0   = 8'd0;
  localparam logic [POS_W-1:0] OFS_SYNC1   = 8'd1;
  localparam logic [POS_W-1:0] OFS_VERSION = 8'd2;
  localparam logic [POS_W-1:0] OFS_COMMAND = 8'd3;
  localparam logic [POS_W-1:0] OFS_LEN_HI  = 8'd4;
  localparam logic [POS_W-1:0] OFS_LEN_LO  = 8'd5;
  localparam logic [POS_W-1:0] HEADER_BYTES = 8'd6;
  localparam logic [LEN_W:0]   MIN_FRAME_BYTES = 17'd7;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'haa;
  localparam logic [BYTE_W-1:0] VERSION_RST     = 8'h00;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_end;
  } in_beat_t;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [BYTE_W-1:0]   command;
    logic [LEN_W-1:0]    payload_length;
    logic [STATUS_W-1:0] status;
  } out_beat_t;

endpackage

// ----- hdl/sync_frame_parser_additive_checksum.sv -----
// sync frame parser top level: header checks, payload pass-through and verdict
// depends on sfpac_pkg and assert_macros.svh
`include "assert_macros.svh"

// Takes one frame byte per beat, a new byte every cycle when not stalled. Each
// byte is handled in the cycle it is accepted (one 8-bit add and a few compares
// against the frame state) and its result, a passed payload byte or the
// end-of-frame verdict, appears in the output register on the next cycle. The
// input is stalled only while that output register is full and the result side
// stalls. Header bytes (offsets 0 to 5) give no output beat. Configuration
// writes are always ready and should be issued only while the parser is idle.
module sync_frame_parser_additive_checksum import sfpac_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

  logic [BYTE_W-1:0]   sync_first_r, sync_second_r, version_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;
  logic [BYTE_W-1:0]   cmd_r, cmd_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                out_valid_r;
  out_beat_t           out_r;

  logic                in_acc;
  logic                out_load;
  logic                has_res;
  out_beat_t           res;
  logic [STATUS_W-1:0] verdict;
  logic [LEN_W:0]      total;
  logic                mismatch;

  assign cfg_ready = 1'b1;
  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = !out_load;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign total    = {{(LEN_W+1-POS_W){1'b0}}, pos_r} + 17'd1;
  assign mismatch = total != (MIN_FRAME_BYTES + {1'b0, len_r});

  always_comb begin
    if (err_r == ST_SYNC || err_r == ST_VERSION) begin
      verdict = err_r;
    end else if (pos_r < HEADER_BYTES) begin
      verdict = ST_SHORT;
    end else if (sum_r != in_data.rx_byte) begin
      verdict = ST_CHECKSUM;
    end else if (err_r == ST_LENGTH || mismatch) begin
      verdict = ST_LENGTH;
    end else begin
      verdict = ST_OK;
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    err_nxt = err_r;
    cmd_nxt = cmd_r;
    len_nxt = len_r;
    has_res = 1'b0;
    res     = '0;
    if (in_data.frame_end) begin
      has_res            = 1'b1;
      res.kind           = 1'b1;
      res.command        = cmd_r;
      res.payload_length = len_r;
      res.status         = verdict;
      pos_nxt = '0;
      sum_nxt = '0;
      err_nxt = ST_OK;
      cmd_nxt = '0;
      len_nxt = '0;
    end else begin
      sum_nxt = sum_r + in_data.rx_byte;
      if (pos_r >= MAX_POS) begin
        if (err_r == ST_OK) err_nxt = ST_LENGTH;
      end else begin
        pos_nxt = pos_r + 8'd1;
      end
      case (pos_r)
        OFS_SYNC0: begin
          if (in_data.rx_byte != sync_first_r && err_nxt == ST_OK) err_nxt = ST_SYNC;
        end
        OFS_SYNC1: begin
          if (in_data.rx_byte != sync_second_r && err_nxt == ST_OK) err_nxt = ST_SYNC;
        end
        OFS_VERSION: begin
          if (in_data.rx_byte != version_r && err_nxt == ST_OK) err_nxt = ST_VERSION;
        end
        OFS_COMMAND: begin
          cmd_nxt = in_data.rx_byte;
        end
        OFS_LEN_HI: begin
          len_nxt = {in_data.rx_byte, 8'h00};
        end
        OFS_LEN_LO: begin
          len_nxt = {len_r[LEN_W-1:BYTE_W], in_data.rx_byte};
        end
        default: begin
          has_res       = 1'b1;
          res.kind      = 1'b0;
          res.data_byte = in_data.rx_byte;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      version_r     <= VERSION_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        CFG_VERSION:     version_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
      err_r <= ST_OK;
      cmd_r <= '0;
      len_r <= '0;
    end else if (in_acc) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
      err_r <= err_nxt;
      cmd_r <= cmd_nxt;
      len_r <= len_nxt;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_acc && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res;
    end
  end

  `ASSERT_ALWAYS(a_stall_only_full, !in_stall || out_valid_r, "input stalled with empty output")
  `ASSERT_ALWAYS(a_pos_bound, pos_r <= MAX_POS, "byte position beyond frame limit")
  `ASSERT_NEXT(a_clear_after_end, in_acc && in_data.frame_end,
    pos_r == '0 && sum_r == '0 && err_r == ST_OK, "frame state not cleared after verdict")
  `ASSERT_ALWAYS(a_payload_clean, !out_valid_r || out_r.kind ||
    (out_r.status == ST_OK && out_r.command == '0 && out_r.payload_length == '0),
    "payload beat carries verdict fields")

endmodule
